// ----- hw/rtl/qdd_pkg.sv -----
`default_nettype none

package qdd_pkg;

    // position counter width, output field width
    localparam int POSITION_BITS = 32;
    localparam int OUT_BITS      = 32;

    localparam int DEBOUNCE_BITS = 16;
    localparam int TICK_BITS     = 16;
    localparam int MODE_BITS     = 3;

    localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 16'd2;
    localparam logic [TICK_BITS-1:0]     TICK_MAX       = '1;

    // item kinds carried on s_tuser
    typedef enum logic [MODE_BITS-1:0] {
        MODE_TICK       = 3'd0,
        MODE_PIN_CHANGE = 3'd1,
        MODE_TAKE_DELTA = 3'd2,
        MODE_READ_CLEAR = 3'd3,
        MODE_ZERO_POS   = 3'd4,
        MODE_RESYNC     = 3'd5
    } mode_t;

    // decoded step per {old ab, new ab}
    typedef enum logic [1:0] {
        STEP_NONE = 2'b00,
        STEP_UP   = 2'b01,
        STEP_DOWN = 2'b11
    } step_t;

    localparam step_t STEP_TABLE [16] = '{
        STEP_NONE, STEP_DOWN, STEP_UP,   STEP_NONE,
        STEP_UP,   STEP_NONE, STEP_NONE, STEP_DOWN,
        STEP_DOWN, STEP_NONE, STEP_NONE, STEP_UP,
        STEP_NONE, STEP_UP,   STEP_DOWN, STEP_NONE
    };

    // result payload: tdata = {delta, position}, tuser = {accepted, changed}
    localparam int M_DATA_BITS = 2 * OUT_BITS;
    localparam int M_USER_BITS = 2;
    localparam int S_DATA_BITS = 8;

endpackage

`default_nettype wire

// ----- hw/rtl/quadrature_decoder_debounced.sv -----
// debounced rotary quadrature decoder
//
// input channel (s_*): one transaction per item. s_tuser carries the item kind:
//   tick, pin change, take delta, read-and-clear changed, zero position, resync.
//   s_tdata carries the a and b pin levels for pin change and resync items.
// result channel (m_*): exactly one transaction per accepted item, in order.
//   m_tdata = {delta, position}, m_tuser = {accepted, changed}.
// configuration channel (cfg_*): writes the debounce threshold in ticks; always
//   ready. The user must write it only while the block is idle; the block does not enforce this.
//
// result path: the result of an item is registered, in the result register or in the skid register.
// throughput: one item per cycle while the skid register is empty; all state is
//   updated in the acceptance cycle by a single pass of short logic (table look-up,
//   one 32-bit add or subtract, one 16-bit compare) into the result or skid register.
// stall: a one-entry skid register behind the result register takes one more
//   item while m_tready is low; s_tready then drops until the skid drains.
// reset (aresetn low, synchronous): position, taken position, stored ab, tick
//   count and changed flag are cleared, debounce returns to 2 ticks, both
//   result registers are emptied and s_tready comes up high.

`default_nettype none

module quadrature_decoder_debounced (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,

    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // [0] pin_a, [1] pin_b, [7:2] zero
    input  wire logic [qdd_pkg::S_DATA_BITS-1:0]     s_tdata,
    // [2:0] mode
    input  wire logic [qdd_pkg::MODE_BITS-1:0]       s_tuser,

    output      logic                                m_tvalid,
    input  wire logic                                m_tready,
    // [31:0] position, [63:32] delta
    output      logic [qdd_pkg::M_DATA_BITS-1:0]     m_tdata,
    // [0] changed, [1] accepted
    output      logic [qdd_pkg::M_USER_BITS-1:0]     m_tuser,

    input  wire logic                                cfg_valid,
    output      logic                                cfg_ready,
    input  wire logic [qdd_pkg::DEBOUNCE_BITS-1:0]   cfg_data
);

    localparam int PB = qdd_pkg::POSITION_BITS;
    localparam int OB = qdd_pkg::OUT_BITS;

    // decoder state
    logic [qdd_pkg::DEBOUNCE_BITS-1:0] debounce_reg;
    logic [PB-1:0]                     position_reg, position_next;
    logic [PB-1:0]                     taken_reg, taken_next;
    logic [1:0]                        ab_reg, ab_next;
    logic [qdd_pkg::TICK_BITS-1:0]     ticks_reg, ticks_next;
    logic                              changed_reg, changed_next;

    // output side: result register plus skid register
    logic                              m_valid_reg, m_valid_next;
    logic [qdd_pkg::M_DATA_BITS-1:0]   m_data_reg, m_data_next;
    logic [qdd_pkg::M_USER_BITS-1:0]   m_user_reg, m_user_next;
    logic                              skid_valid_reg, skid_valid_next;
    logic [qdd_pkg::M_DATA_BITS-1:0]   skid_data_reg, skid_data_next;
    logic [qdd_pkg::M_USER_BITS-1:0]   skid_user_reg, skid_user_next;
    logic                              s_ready_reg, s_ready_next;

    logic                              in_fire;
    logic                              out_free;
    logic [1:0]                        new_ab;
    qdd_pkg::step_t                    step;
    logic [PB-1:0]                     delta_val;
    logic                              changed_out;
    logic                              accepted_out;
    logic [qdd_pkg::M_DATA_BITS-1:0]   res_data;
    logic [qdd_pkg::M_USER_BITS-1:0]   res_user;

    assign in_fire   = s_tvalid && s_ready_reg;
    assign out_free  = !m_valid_reg || m_tready;
    assign cfg_ready = 1'b1;

    // ab encoded as {a, b}
    assign new_ab = {s_tdata[0], s_tdata[1]};
    assign step   = qdd_pkg::STEP_TABLE[{ab_reg, new_ab}];

    // one pass over the item: next state and result fields
    always_comb begin
        position_next = position_reg;
        taken_next    = taken_reg;
        ab_next       = ab_reg;
        ticks_next    = ticks_reg;
        changed_next  = changed_reg;
        delta_val     = '0;
        accepted_out  = 1'b0;
        changed_out   = changed_reg;

        unique case (s_tuser)
            qdd_pkg::MODE_TICK: begin
                if (ticks_reg != qdd_pkg::TICK_MAX) begin
                    ticks_next = ticks_reg + 1'b1;
                end
            end
            qdd_pkg::MODE_PIN_CHANGE: begin
                if (ticks_reg >= debounce_reg) begin
                    accepted_out = 1'b1;
                    ticks_next   = '0;
                    ab_next      = new_ab;
                    unique case (step)
                        qdd_pkg::STEP_UP: begin
                            position_next = position_reg + 1'b1;
                            changed_next  = 1'b1;
                        end
                        qdd_pkg::STEP_DOWN: begin
                            position_next = position_reg - 1'b1;
                            changed_next  = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                changed_out = changed_next;
            end
            qdd_pkg::MODE_TAKE_DELTA: begin
                delta_val  = position_reg - taken_reg;
                taken_next = position_reg;
            end
            qdd_pkg::MODE_READ_CLEAR: begin
                // report the flag as read, then clear it
                changed_next = 1'b0;
            end
            qdd_pkg::MODE_ZERO_POS: begin
                position_next = '0;
                changed_next  = 1'b1;
                changed_out   = 1'b1;
            end
            qdd_pkg::MODE_RESYNC: begin
                ab_next = new_ab;
            end
            default: begin
                // undefined kinds leave the state alone
            end
        endcase
    end

    assign res_data = {OB'(delta_val), OB'(position_next)};
    assign res_user = {accepted_out, changed_out};

    // result register and skid steering
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_user_next  = skid_user_reg;

        if (out_free) begin
            if (skid_valid_reg) begin
                // skid drains first; no new item is taken while it is full
                m_valid_next    = 1'b1;
                m_data_next     = skid_data_reg;
                m_user_next     = skid_user_reg;
                skid_valid_next = 1'b0;
            end else if (in_fire) begin
                m_valid_next = 1'b1;
                m_data_next  = res_data;
                m_user_next  = res_user;
            end else begin
                m_valid_next = 1'b0;
            end
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_data;
            skid_user_next  = res_user;
        end

        s_ready_next = !skid_valid_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= qdd_pkg::DEBOUNCE_RESET;
            position_reg   <= '0;
            taken_reg      <= '0;
            ab_reg         <= '0;
            ticks_reg      <= '0;
            changed_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
            s_ready_reg    <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                debounce_reg <= cfg_data;
            end
            if (in_fire) begin
                position_reg <= position_next;
                taken_reg    <= taken_next;
                ab_reg       <= ab_next;
                ticks_reg    <= ticks_next;
                changed_reg  <= changed_next;
            end
            m_valid_reg    <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
            s_ready_reg    <= s_ready_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
        skid_data_reg <= skid_data_next;
        skid_user_reg <= skid_user_next;
    end

    assign s_tready = s_ready_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/qdd_checker.sv -----
`default_nettype none

module qdd_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [qdd_pkg::M_DATA_BITS-1:0]   m_tdata,
    input wire logic [qdd_pkg::M_USER_BITS-1:0]   m_tuser
);

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // after every accepted item, m_tvalid is high on the next cycle
    a_in_to_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item produced no result");

    // input only backs up once the result register is occupied
    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result register");

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("result side not empty after reset");

endmodule

bind quadrature_decoder_debounced qdd_checker u_qdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
